[sv/spq_pkg.sv]
// Package: capacity, codes, payload and RAM request types for the sorted priority queue.
package spq_pkg;

  localparam int unsigned CAPACITY = 8;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned FILL_W   = 4;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned PRIO_W   = 8;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   entry_id;
    logic [PRIO_W-1:0] entry_priority;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   out_id;
    logic [PRIO_W-1:0] out_priority;
    logic [FILL_W-1:0] fill_count;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  // Low four bits of a held count, zero-extended when the count is narrower.
  function automatic logic [FILL_W-1:0] to_fill(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+FILL_W-1:0] wide;
    wide = {{FILL_W{1'b0}}, cnt};
    return wide[FILL_W-1:0];
  endfunction

endpackage

[sv/spq_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module spq_ram #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned WIDTH  = 24,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/spq_ctrl.sv]
// Sequencer: walks the sorted entry RAM to insert, pop and shift entries.
module spq_ctrl import spq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output out_item_t res_o,
  output ram_req_t  ram_req_o,
  input  entry_t    ram_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_STEP,
    S_POP_HEAD,
    S_POP_SHIFT,
    S_RESP
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  in_item_t         item_q, item_d;
  out_item_t        res_q, res_d;
  logic [CNT_W-1:0] raddr_full;
  logic [CNT_W-1:0] waddr_full;
  entry_t           new_entry;

  assign new_entry = '{id: item_q.entry_id, prio: item_q.entry_priority};

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pos_d      = pos_q;
    item_d     = item_q;
    res_d      = res_q;
    raddr_full = '0;
    waddr_full = '0;
    ram_req_o  = '0;
    ram_req_o.wdata = new_entry;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_item_i;
          unique case (in_item_i.op)
            OP_INSERT: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                res_d   = '{status: ST_FULL, out_id: '0, out_priority: '0,
                            fill_count: to_fill(count_q)};
                state_d = S_RESP;
              end else if (count_q == '0) begin
                // Empty queue: place the entry at the head directly.
                ram_req_o.we    = 1'b1;
                ram_req_o.wdata = '{id: in_item_i.entry_id,
                                    prio: in_item_i.entry_priority};
                count_d = CNT_W'(1);
                res_d   = '{status: ST_OK, out_id: '0, out_priority: '0,
                            fill_count: to_fill(CNT_W'(1))};
                state_d = S_RESP;
              end else begin
                raddr_full   = count_q - CNT_W'(1);
                ram_req_o.re = 1'b1;
                pos_d        = count_q;
                state_d      = S_INS_STEP;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                res_d   = '{status: ST_EMPTY, out_id: '0, out_priority: '0,
                            fill_count: to_fill(count_q)};
                state_d = S_RESP;
              end else begin
                ram_req_o.re = 1'b1;
                state_d      = S_POP_HEAD;
              end
            end
            default: ;
          endcase
        end
      end

      S_INS_STEP: begin
        waddr_full   = pos_q;
        ram_req_o.we = 1'b1;
        if ((pos_q != '0) && (ram_rdata_i.prio > item_q.entry_priority)) begin
          // Move the larger entry back one place and look at the next one.
          ram_req_o.wdata = ram_rdata_i;
          pos_d           = pos_q - CNT_W'(1);
          if (pos_q >= CNT_W'(2)) begin
            raddr_full   = pos_q - CNT_W'(2);
            ram_req_o.re = 1'b1;
          end
        end else begin
          count_d = count_q + CNT_W'(1);
          res_d   = '{status: ST_OK, out_id: '0, out_priority: '0,
                      fill_count: to_fill(count_q + CNT_W'(1))};
          state_d = S_RESP;
        end
      end

      S_POP_HEAD: begin
        count_d = count_q - CNT_W'(1);
        res_d   = '{status: ST_OK, out_id: ram_rdata_i.id,
                    out_priority: ram_rdata_i.prio,
                    fill_count: to_fill(count_q - CNT_W'(1))};
        if (count_q >= CNT_W'(2)) begin
          raddr_full   = CNT_W'(1);
          ram_req_o.re = 1'b1;
          pos_d        = '0;
          state_d      = S_POP_SHIFT;
        end else begin
          state_d = S_RESP;
        end
      end

      S_POP_SHIFT: begin
        // count_q already holds the reduced count here.
        waddr_full      = pos_q;
        ram_req_o.we    = 1'b1;
        ram_req_o.wdata = ram_rdata_i;
        pos_d           = pos_q + CNT_W'(1);
        if ((pos_q + CNT_W'(1)) < count_q) begin
          raddr_full   = pos_q + CNT_W'(2);
          ram_req_o.re = 1'b1;
        end else begin
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    ram_req_o.raddr = raddr_full[IDX_W-1:0];
    ram_req_o.waddr = waddr_full[IDX_W-1:0];
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_rw_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req_o.we && ram_req_o.re && (ram_req_o.waddr == ram_req_o.raddr)))
    else $error("read and write of the same entry in one cycle");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> ((count_q == $past(count_q) + CNT_W'(1)) ||
                           (count_q == $past(count_q) - CNT_W'(1))))
    else $error("entry count moved by more than one");

  a_resp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_o)))
    else $error("result dropped before it was taken");

endmodule

[sv/sorted_priority_queue.sv]
// Top level: sorted priority queue with entry RAM, sequencer and output register.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) carries one command item:
//   op = OP_INSERT stores entry_id with entry_priority behind every held entry of
//   equal or lower value (ties leave first in, first out); op = OP_POP removes the
//   entry with the lowest priority value. Every input item yields one result item
//   on the output channel (out_valid_o / out_ready_i / out_item_o) with a status
//   (ok, full, empty), the popped id and priority (zero otherwise) and the count
//   of entries held afterwards.
// Timing:
//   The entries live in one RAM with a registered read; the sequencer moves one
//   entry per cycle. An insert into a non-empty queue first moves every held
//   entry of higher priority value back one place, a pop shifts every entry
//   left behind forward one place, and a refused item or an insert into an empty
//   queue goes straight to its result. The next item is taken only after the
//   result has entered the output register. Only one item is in work at a time.
// Reset:
//   rst_ni (asynchronous, active low) empties the queue; RAM contents are left
//   as is and are never read before they are written.
// Stall:
//   A result waits in the output register while out_ready_i is low; the next
//   item is still accepted and worked on, and holds only at its own result.
module sorted_priority_queue import spq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      res_valid;
  logic      res_ready;
  out_item_t res;
  ram_req_t  ram_req;
  entry_t    ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  logic      out_valid_q;
  out_item_t out_item_q;

  // Sequencer: owns the entry count and drives every RAM access.
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Sorted entry store, head of the queue at address zero.
  spq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // Output register: take a new result when empty or being drained this cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the payload while stalled; load it only with a new result.
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[test/tb_top.sv]
// Testbench for the sorted priority queue: shadow queue, random traffic and result checks.
`timescale 1ns / 100ps

module tb_top;
  import spq_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 850;
  localparam int unsigned HOLD_CYCLES    = 400;
  // Allow for the slowest item, the longest gaps and stalls and the long receiver hold
  // of HOLD_CYCLES: take that several times over.
  localparam int unsigned WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + 2 * 40 + CAPACITY + 2);
  localparam int unsigned DRAIN_CYCLES   = 4 * (CAPACITY + 2);
  localparam int unsigned REPORT_MAX     = 10;

  // Shadow of the queue contents; predicts one result per accepted command.
  class pq_shadow;
    entry_t      held[$];
    out_item_t   pending_results[$];
    int unsigned mismatches;

    function void flag(string msg);
      if (mismatches < REPORT_MAX) $display("ERROR: %s", msg);
      mismatches++;
    endfunction

    function void note_command(in_item_t cmd);
      out_item_t res;
      entry_t    head;
      entry_t    fresh;
      int        pos;
      res = '0;
      res.status = ST_OK;
      if (cmd.op == OP_INSERT) begin
        if (held.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          fresh.id   = cmd.entry_id;
          fresh.prio = cmd.entry_priority;
          // go behind every entry of equal or lower value, so ties stay first in, first out
          pos = held.size();
          while (pos > 0 && held[pos-1].prio > fresh.prio) pos--;
          held.insert(pos, fresh);
        end
      end else begin
        if (held.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          head = held.pop_front();
          res.out_id       = head.id;
          res.out_priority = head.prio;
        end
      end
      res.fill_count = FILL_W'(held.size());
      pending_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        flag($sformatf("result with nothing pending: %p", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.out_id !== want.out_id ||
          got.out_priority !== want.out_priority || got.fill_count !== want.fill_count)
        flag($sformatf("expected status=%0d id=%h prio=%h fill=%0d, got status=%0d id=%h prio=%h fill=%0d",
                       want.status, want.out_id, want.out_priority, want.fill_count,
                       got.status, got.out_id, got.out_priority, got.fill_count));
    endfunction

    function void check_drained();
      if (pending_results.size() != 0)
        flag($sformatf("%0d results never arrived", pending_results.size()));
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  pq_shadow  shadow = new();
  bit        gaps_on = 1'b0;
  bit        stalls_on = 1'b0;
  int        hold_requests = 0;

  sorted_priority_queue DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Favor a few small values so ties are common, and hit both extremes.
  function automatic logic [PRIO_W-1:0] pick_priority();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return PRIO_W'($urandom_range(0, 3));
    if (r < 40) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return PRIO_W'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t make_item(op_e op, logic [ID_W-1:0] id,
                                         logic [PRIO_W-1:0] prio);
    in_item_t cmd;
    cmd.op             = op;
    cmd.entry_id       = id;
    cmd.entry_priority = prio;
    return cmd;
  endfunction

  // Offer one item and hold it until the queue takes it; called right after a rising edge.
  task automatic send_item(input in_item_t cmd);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= cmd;
    do @(posedge clk_i); while (!in_ready);
    shadow.note_command(cmd);
  endtask

  task automatic send_directed();
    send_item(make_item(OP_POP,    16'hBEEF, 8'h5C));
    send_item(make_item(OP_INSERT, 16'hFFFF, 8'hFF));
    send_item(make_item(OP_INSERT, 16'h0000, 8'h00));
    send_item(make_item(OP_INSERT, 16'h1234, 8'h00));
    send_item(make_item(OP_INSERT, 16'hA5A5, 8'h80));
    send_item(make_item(OP_INSERT, 16'h5A5A, 8'h80));
    send_item(make_item(OP_INSERT, 16'h0001, 8'hFF));
    send_item(make_item(OP_INSERT, 16'h00FF, 8'h7F));
    send_item(make_item(OP_INSERT, 16'hFF00, 8'h01));
    // queue is full now: both inserts must be refused
    send_item(make_item(OP_INSERT, 16'h7777, 8'h00));
    send_item(make_item(OP_INSERT, 16'hFFFF, 8'hFF));
    repeat (CAPACITY) send_item(make_item(OP_POP, 16'hFFFF, 8'hFF));
    send_item(make_item(OP_POP,    16'h0000, 8'h00));
    send_item(make_item(OP_INSERT, 16'h4242, 8'h42));
    send_item(make_item(OP_POP,    16'h0000, 8'h00));
  endtask

  // Bursts that lean toward filling, draining or neither, so both full and empty recur.
  task automatic send_random();
    int unsigned sent;
    int unsigned burst;
    int          insert_pct;
    op_e         op;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst      = $urandom_range(5, 30);
      insert_pct = ($urandom_range(0, 2) == 0) ? 50 : (($urandom_range(0, 1) != 0) ? 80 : 20);
      gaps_on    = ($urandom_range(0, 3) != 0);
      stalls_on  = ($urandom_range(0, 3) != 0);
      repeat (burst) begin
        if (sent == 200 || sent == 600) begin
          // hold off the receiver and keep offering, so the queue backs up
          gaps_on = 1'b0;
          hold_requests++;
        end
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
        send_item(make_item(op, ID_W'($urandom_range(0, 65535)), pick_priority()));
        sent++;
      end
    end
  endtask

  // Receiver: check each accepted result, then pick the next ready value.
  initial begin
    int stall_left;
    int holds_seen;
    stall_left = 0;
    holds_seen = 0;
    wait (rst_n);
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) shadow.check_result(out_item);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    send_directed();
    send_random();
    @(posedge clk_i);
    in_valid <= 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk_i);
    // let any stray result show up before the final verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    shadow.check_drained();
    if (shadow.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
